>>> src/char_stream_tokenizer_top_macros.svh
// Assertion macros shared by the tokenizer RTL.
`ifndef CHAR_STREAM_TOKENIZER_TOP_MACROS_SVH
`define CHAR_STREAM_TOKENIZER_TOP_MACROS_SVH

// Check that a condition implies another in the same cycle (clk / rst_n by name).
`define CST_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the following cycle.
`define CST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/cst_pkg.sv
// Shared types and constants of the character stream tokenizer.
package cst_pkg;

    localparam int TEXT_CHARS  = 8;
    localparam int MAX_RESULTS = 4;
    localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
    localparam logic [RES_CNT_W-1:0] RES_CNT_MAX = RES_CNT_W'(MAX_RESULTS);

    // Token kinds
    localparam logic [3:0] KIND_INT     = 4'd0;
    localparam logic [3:0] KIND_FLOAT   = 4'd1;
    localparam logic [3:0] KIND_IDENT   = 4'd2;
    localparam logic [3:0] KIND_LPAR    = 4'd3;
    localparam logic [3:0] KIND_RPAR    = 4'd4;
    localparam logic [3:0] KIND_DOT     = 4'd5;
    localparam logic [3:0] KIND_COLON   = 4'd6;
    localparam logic [3:0] KIND_SEMI    = 4'd7;
    localparam logic [3:0] KIND_COMMA   = 4'd8;
    localparam logic [3:0] KIND_PLUS    = 4'd9;
    localparam logic [3:0] KIND_MINUS   = 4'd10;
    localparam logic [3:0] KIND_MUL     = 4'd11;
    localparam logic [3:0] KIND_DIV     = 4'd12;
    localparam logic [3:0] KIND_ASSIGN  = 4'd13;
    localparam logic [3:0] KIND_END     = 4'd14;
    localparam logic [3:0] KIND_UNKNOWN = 4'd15;

    // Character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;

    typedef struct packed {
        logic [3:0]  kind;
        logic [30:0] int_value;
        logic [31:0] frac_value;
        logic [7:0]  frac_digits;
        logic [63:0] text;
        logic [7:0]  text_length;
        logic        last;
    } res_t;

    // Results caused by one input item
    typedef struct packed {
        logic [RES_CNT_W-1:0]   cnt;
        res_t [MAX_RESULTS-1:0] slot;
    } bundle_t;

endpackage

>>> src/cst_lexer.sv
// Lexer state and single-pass next-state / result logic of the tokenizer.
module cst_lexer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        ch,
    input  logic              at_end,
    input  logic              advance,
    output cst_pkg::bundle_t  bundle
);

    typedef enum logic [2:0] {
        MODE_DEFAULT = 3'd0,
        MODE_INT     = 3'd1,
        MODE_IDENT   = 3'd2,
        MODE_SLASH   = 3'd3,
        MODE_LINE    = 3'd4,
        MODE_BLOCK   = 3'd5,
        MODE_STAR    = 3'd6
    } mode_t;

    typedef struct packed {
        mode_t       mode;
        logic [31:0] num;
        logic [63:0] txt;
        logic [7:0]  len;
        logic [1:0]  hcnt;
        logic [31:0] hval;
        logic [63:0] htxt;
        logic [7:0]  hlen;
    } lex_st_t;

    typedef struct packed {
        lex_st_t          st;
        cst_pkg::bundle_t b;
    } step_t;

    lex_st_t state_reg;
    lex_st_t state_next;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= cst_pkg::CH_0) && (c <= cst_pkg::CH_9);
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= cst_pkg::CH_LA) && (c <= cst_pkg::CH_LZ)) ||
               ((c >= cst_pkg::CH_UA) && (c <= cst_pkg::CH_UZ));
    endfunction

    function automatic logic [30:0] clamp31(logic [31:0] v);
        return v[31] ? {31{1'b1}} : v[30:0];
    endfunction

    function automatic cst_pkg::res_t mk_res(logic [3:0] kind, logic [30:0] iv,
                                             logic [31:0] fv, logic [7:0] fd,
                                             logic [63:0] txt, logic [7:0] len);
        cst_pkg::res_t r;
        r.kind        = kind;
        r.int_value   = iv;
        r.frac_value  = fv;
        r.frac_digits = fd;
        r.text        = txt;
        r.text_length = len;
        r.last        = 1'b0;
        return r;
    endfunction

    function automatic lex_st_t clear_accum(lex_st_t st);
        lex_st_t o;
        o     = st;
        o.num = '0;
        o.txt = '0;
        o.len = '0;
        return o;
    endfunction

    function automatic lex_st_t add_char(lex_st_t st, logic [7:0] c);
        lex_st_t o;
        o = st;
        if (o.len < 8'(cst_pkg::TEXT_CHARS))
            o.txt[{o.len[2:0], 3'b000} +: 8] = c;
        if (o.len != 8'hFF)
            o.len = o.len + 8'd1;
        return o;
    endfunction

    function automatic step_t emit_raw(step_t s, cst_pkg::res_t r);
        step_t o;
        o = s;
        if (o.b.cnt < cst_pkg::RES_CNT_MAX)
        begin
            o.b.slot[o.b.cnt[cst_pkg::RES_IDX_W-1:0]] = r;
            o.b.cnt = o.b.cnt + 1'b1;
        end
        return o;
    endfunction

    function automatic step_t flush_held(step_t s);
        step_t o;
        o = s;
        if (o.st.hcnt >= 2'd1)
            o = emit_raw(o, mk_res(cst_pkg::KIND_INT, clamp31(o.st.hval), 32'd0, 8'd0,
                                   o.st.htxt, o.st.hlen));
        if (o.st.hcnt >= 2'd2)
            o = emit_raw(o, mk_res(cst_pkg::KIND_DOT, 31'd0, 32'd0, 8'd0,
                                   {56'd0, cst_pkg::CH_DOT}, 8'd1));
        o.st.hcnt = '0;
        o.st.hval = '0;
        o.st.htxt = '0;
        o.st.hlen = '0;
        return o;
    endfunction

    function automatic step_t emit_other(step_t s, logic [3:0] kind,
                                         logic [63:0] txt, logic [7:0] len);
        return emit_raw(flush_held(s), mk_res(kind, 31'd0, 32'd0, 8'd0, txt, len));
    endfunction

    // Merge held INT and DOT with the int in progress
    function automatic step_t emit_float(step_t s);
        logic [63:0] t;
        logic [9:0]  p;
        logic [9:0]  total;
        logic [7:0]  tlen;
        t = s.st.htxt;
        if (s.st.hlen < 8'(cst_pkg::TEXT_CHARS))
            t[{s.st.hlen[2:0], 3'b000} +: 8] = cst_pkg::CH_DOT;
        for (int i = 0; i < cst_pkg::TEXT_CHARS; i++)
        begin
            p = 10'(s.st.hlen) + 10'd1 + 10'(i);
            if ((8'(i) < s.st.len) && (p < 10'(cst_pkg::TEXT_CHARS)))
                t[{p[2:0], 3'b000} +: 8] = s.st.txt[8*i +: 8];
        end
        total = 10'(s.st.hlen) + 10'd1 + 10'(s.st.len);
        tlen  = (total > 10'd255) ? 8'hFF : total[7:0];
        return emit_raw(s, mk_res(cst_pkg::KIND_FLOAT, clamp31(s.st.hval), s.st.num,
                                  s.st.len, t, tlen));
    endfunction

    function automatic step_t finish_int(step_t s);
        step_t o;
        o = s;
        if (o.st.hcnt >= 2'd2)
        begin
            o = emit_float(o);
            o.st.hcnt = '0;
            o.st.hval = '0;
            o.st.htxt = '0;
            o.st.hlen = '0;
        end
        else
        begin
            if (o.st.hcnt == 2'd1)
                o = emit_raw(o, mk_res(cst_pkg::KIND_INT, clamp31(o.st.hval), 32'd0, 8'd0,
                                       o.st.htxt, o.st.hlen));
            o.st.hcnt = 2'd1;
            o.st.hval = o.st.num;
            o.st.htxt = o.st.txt;
            o.st.hlen = o.st.len;
        end
        o.st = clear_accum(o.st);
        return o;
    endfunction

    function automatic step_t got_dot(step_t s);
        step_t o;
        o = s;
        if (o.st.hcnt == 2'd1)
            o.st.hcnt = 2'd2;
        else
            o = emit_raw(flush_held(o), mk_res(cst_pkg::KIND_DOT, 31'd0, 32'd0, 8'd0,
                                               {56'd0, cst_pkg::CH_DOT}, 8'd1));
        return o;
    endfunction

    function automatic step_t lex_default(step_t s, logic [7:0] c);
        step_t o;
        o = s;
        o.st.mode = MODE_DEFAULT;
        unique case (c) inside
            cst_pkg::CH_SP, cst_pkg::CH_TAB, cst_pkg::CH_CR, cst_pkg::CH_LF: ;
            cst_pkg::CH_DOT:   o = got_dot(o);
            cst_pkg::CH_COLON: o = emit_other(o, cst_pkg::KIND_COLON, {56'd0, c}, 8'd1);
            cst_pkg::CH_SEMI:  o = emit_other(o, cst_pkg::KIND_SEMI, {56'd0, c}, 8'd1);
            cst_pkg::CH_COMMA: o = emit_other(o, cst_pkg::KIND_COMMA, {56'd0, c}, 8'd1);
            cst_pkg::CH_PLUS:  o = emit_other(o, cst_pkg::KIND_PLUS, {56'd0, c}, 8'd1);
            cst_pkg::CH_MINUS: o = emit_other(o, cst_pkg::KIND_MINUS, {56'd0, c}, 8'd1);
            cst_pkg::CH_STAR:  o = emit_other(o, cst_pkg::KIND_MUL, {56'd0, c}, 8'd1);
            cst_pkg::CH_EQ:    o = emit_other(o, cst_pkg::KIND_ASSIGN, {56'd0, c}, 8'd1);
            cst_pkg::CH_LPAR:  o = emit_other(o, cst_pkg::KIND_LPAR, {56'd0, c}, 8'd1);
            cst_pkg::CH_RPAR:  o = emit_other(o, cst_pkg::KIND_RPAR, {56'd0, c}, 8'd1);
            cst_pkg::CH_SLASH: o.st.mode = MODE_SLASH;
            [cst_pkg::CH_0:cst_pkg::CH_9]:
            begin
                o.st      = clear_accum(o.st);
                o.st.num  = {24'd0, c - cst_pkg::CH_0};
                o.st      = add_char(o.st, c);
                o.st.mode = MODE_INT;
            end
            [cst_pkg::CH_UA:cst_pkg::CH_UZ], [cst_pkg::CH_LA:cst_pkg::CH_LZ]:
            begin
                o.st      = clear_accum(o.st);
                o.st      = add_char(o.st, c);
                o.st.mode = MODE_IDENT;
            end
            default:           o = emit_other(o, cst_pkg::KIND_UNKNOWN, {56'd0, c}, 8'd1);
        endcase
        return o;
    endfunction

    always_comb
    begin
        step_t       s;
        logic [35:0] prod;
        s.st = state_reg;
        s.b  = '0;
        prod = '0;
        if (at_end)
        begin
            // complete pending token, flush held ones, then END and back to reset
            unique case (s.st.mode)
                MODE_INT:   s = finish_int(s);
                MODE_IDENT: s = emit_other(s, cst_pkg::KIND_IDENT, s.st.txt, s.st.len);
                MODE_SLASH: s = emit_other(s, cst_pkg::KIND_DIV,
                                           {56'd0, cst_pkg::CH_SLASH}, 8'd1);
                default:    ;
            endcase
            s    = flush_held(s);
            s    = emit_raw(s, mk_res(cst_pkg::KIND_END, 31'd0, 32'd0, 8'd0, 64'd0, 8'd0));
            s.st = '0;
        end
        else
        begin
            unique case (s.st.mode)
                MODE_INT:
                begin
                    if (is_digit(ch))
                    begin
                        // num * 10 + digit, saturate at 32 bits
                        prod = {1'b0, s.st.num, 3'b000} + {3'b000, s.st.num, 1'b0}
                             + {28'd0, ch - cst_pkg::CH_0};
                        s.st.num = (prod[35:32] != 4'd0) ? 32'hFFFF_FFFF : prod[31:0];
                        s.st     = add_char(s.st, ch);
                    end
                    else
                    begin
                        s = finish_int(s);
                        s = lex_default(s, ch);
                    end
                end
                MODE_IDENT:
                begin
                    if (is_digit(ch) || is_alpha(ch))
                        s.st = add_char(s.st, ch);
                    else
                    begin
                        s    = emit_other(s, cst_pkg::KIND_IDENT, s.st.txt, s.st.len);
                        s.st = clear_accum(s.st);
                        s    = lex_default(s, ch);
                    end
                end
                MODE_SLASH:
                begin
                    if (ch == cst_pkg::CH_SLASH)
                        s.st.mode = MODE_LINE;
                    else if (ch == cst_pkg::CH_STAR)
                        s.st.mode = MODE_BLOCK;
                    else
                    begin
                        s = emit_other(s, cst_pkg::KIND_DIV, {56'd0, cst_pkg::CH_SLASH}, 8'd1);
                        s = lex_default(s, ch);
                    end
                end
                MODE_LINE:
                begin
                    if (ch == cst_pkg::CH_LF)
                        s.st.mode = MODE_DEFAULT;
                end
                MODE_BLOCK:
                begin
                    if (ch == cst_pkg::CH_STAR)
                        s.st.mode = MODE_STAR;
                end
                MODE_STAR:
                begin
                    if (ch == cst_pkg::CH_SLASH)
                        s.st.mode = MODE_DEFAULT;
                    else if (ch != cst_pkg::CH_STAR)
                        s.st.mode = MODE_BLOCK;
                end
                default: s = lex_default(s, ch);
            endcase
        end
        // mark the final result of this item
        if (s.b.cnt != '0)
            s.b.slot[s.b.cnt[cst_pkg::RES_IDX_W-1:0] - 1'b1].last = 1'b1;
        state_next = s.st;
        bundle     = s.b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (advance)
            state_reg <= state_next;
    end

endmodule

>>> src/char_stream_tokenizer_top.sv
// Top level of the character stream tokenizer: handshakes, item register, result buffer.
//
//  channel | handshake            | payload                                      | dir
//  --------+----------------------+----------------------------------------------+----
//  source  | src_valid, src_stall | ch, at_end                                   | in
//  tokens  | tok_valid, tok_stall | kind, int_value, frac_value, frac_digits,    | out
//          |                      | text, text_length, last                      |
//
//  A transfer lands in the item register; the lexer turns it into tokens in one pass
//  and the result buffer loads them once it is free. Items follow back to back unless
//  the buffer stalls; an item with k tokens (k <= 4) holds the buffer until all are taken.
//  rst_n (asynchronous, active low) returns the lexer to its default mode with nothing
//  held and empties both registers. A token stall reaches src_stall only while the held
//  item yields tokens and the buffer is not draining its final one.
`include "char_stream_tokenizer_top_macros.svh"

module char_stream_tokenizer_top (
    input  logic        clk,
    input  logic        rst_n,
    // source channel
    input  logic        src_valid,
    output logic        src_stall,
    input  logic [7:0]  ch,
    input  logic        at_end,
    // token channel
    output logic        tok_valid,
    input  logic        tok_stall,
    output logic [3:0]  kind,
    output logic [30:0] int_value,
    output logic [31:0] frac_value,
    output logic [7:0]  frac_digits,
    output logic [63:0] text,
    output logic [7:0]  text_length,
    output logic        last
);

    // Item register
    logic       item_vld_reg;
    logic       item_vld_next;
    logic [7:0] item_ch_reg;
    logic       item_end_reg;

    // Result buffer: the tokens of one item, read out in order
    logic [cst_pkg::RES_CNT_W-1:0]            cnt_reg;
    logic [cst_pkg::RES_CNT_W-1:0]            cnt_next;
    logic [cst_pkg::RES_IDX_W-1:0]            idx_reg;
    logic [cst_pkg::RES_IDX_W-1:0]            idx_next;
    cst_pkg::res_t [cst_pkg::MAX_RESULTS-1:0] slot_reg;

    cst_pkg::bundle_t lex_bundle;
    cst_pkg::res_t    cur;

    logic src_xfer;
    logic tok_xfer;
    logic drain_done;
    logic buf_free;
    logic consume;
    logic load;

    cst_lexer u_lexer (
        .clk     (clk),
        .rst_n   (rst_n),
        .ch      (item_ch_reg),
        .at_end  (item_end_reg),
        .advance (consume),
        .bundle  (lex_bundle)
    );

    // Token side: show the current buffer entry
    assign cur         = slot_reg[idx_reg];
    assign tok_valid   = (cnt_reg != '0);
    assign kind        = cur.kind;
    assign int_value   = cur.int_value;
    assign frac_value  = cur.frac_value;
    assign frac_digits = cur.frac_digits;
    assign text        = cur.text;
    assign text_length = cur.text_length;
    assign last        = cur.last;

    assign tok_xfer   = tok_valid && !tok_stall;
    assign drain_done = tok_xfer && cur.last;
    assign buf_free   = (cnt_reg == '0) || drain_done;

    // Advance the lexer on the held item when its tokens have room; an item
    // that yields nothing never waits.
    assign consume   = item_vld_reg && ((lex_bundle.cnt == '0) || buf_free);
    assign load      = consume && (lex_bundle.cnt != '0);
    assign src_stall = item_vld_reg && !consume;
    assign src_xfer  = src_valid && !src_stall;

    always_comb
    begin
        item_vld_next = item_vld_reg;
        if (src_xfer)
            item_vld_next = 1'b1;
        else if (consume)
            item_vld_next = 1'b0;

        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (load)
        begin
            cnt_next = lex_bundle.cnt;
            idx_next = '0;
        end
        else if (drain_done)
        begin
            cnt_next = '0;
            idx_next = '0;
        end
        else if (tok_xfer)
            idx_next = idx_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            cnt_reg      <= '0;
            idx_reg      <= '0;
        end
        else
        begin
            item_vld_reg <= item_vld_next;
            cnt_reg      <= cnt_next;
            idx_reg      <= idx_next;
        end
    end

    // Payload: capture on transfer, hold otherwise
    always_ff @(posedge clk)
    begin
        if (src_xfer)
        begin
            item_ch_reg  <= ch;
            item_end_reg <= at_end;
        end
        if (load)
            slot_reg <= lex_bundle.slot;
    end

    `CST_ASSERT_IMPLY(a_idx_in_range, tok_valid,
        (cst_pkg::RES_CNT_W'(idx_reg) < cnt_reg), "read index past token count")
    `CST_ASSERT_NEXT(a_item_held, item_vld_reg && !consume,
        item_vld_reg && $stable(item_ch_reg) && $stable(item_end_reg),
        "held item lost or changed")
    `CST_ASSERT_NEXT(a_load_starts, load, tok_valid && (idx_reg == '0),
        "new tokens not shown from first entry")
    `CST_ASSERT_NEXT(a_drain_empties, drain_done && !load, !tok_valid,
        "buffer not empty after final token")

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the character stream tokenizer top level.
`timescale 1ns / 1ps

module tb_top;

    // Lower bound on the input items sent, whitespace and comment bodies included. The
    // total includes one very long float.
    localparam int ITEMS = 430;
    // Cycle ceiling. The slowest correct run is far below this, even with 4 tokens per
    // item and every stall at its longest.
    localparam int CYCLE_LIMIT = 300000;
    // Cycles to linger once the last token is in: a transfer passes the item register
    // and the result buffer before it shows, and the linger lets any stray token appear.
    localparam int TAIL_CYCLES = 10;

    // Lexer modes of the predictor
    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_NUM,
        SCAN_WORD,
        SCAN_SLASH,
        SCAN_LINE_CMT,
        SCAN_BLOCK_CMT,
        SCAN_BLOCK_STAR
    } scan_mode_e;

    // One row of the stimulus plan. A typed row carries its single token
    // written out by hand. Every other row is checked against the predictor.
    typedef struct {
        logic [7:0]    chr;
        logic          fin;
        bit            typed;
        cst_pkg::res_t want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        src_valid;
    logic        src_stall;
    logic [7:0]  ch;
    logic        at_end;
    logic        tok_valid;
    logic        tok_stall;
    logic [3:0]  kind;
    logic [30:0] int_value;
    logic [31:0] frac_value;
    logic [7:0]  frac_digits;
    logic [63:0] text;
    logic [7:0]  text_length;
    logic        last;

    stim_row_t     plan[$];
    cst_pkg::res_t tok_expect[$];
    int            row_idx;
    int            rand_start;
    int            errors = 0;
    int            cycles = 0;

    char_stream_tokenizer_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .src_valid   (src_valid),
        .src_stall   (src_stall),
        .ch          (ch),
        .at_end      (at_end),
        .tok_valid   (tok_valid),
        .tok_stall   (tok_stall),
        .kind        (kind),
        .int_value   (int_value),
        .frac_value  (frac_value),
        .frac_digits (frac_digits),
        .text        (text),
        .text_length (text_length),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Token predictor: the lexer state is mirrored here and stepped once
    // for every accepted source transfer.
    // ------------------------------------------------------------------
    scan_mode_e    scan_mode;
    logic [31:0]   num_acc;
    logic [63:0]   txt_acc;
    logic [7:0]    len_acc;
    logic [1:0]    held_n;      // 0 nothing held, 1 int held, 2 int and dot held
    logic [31:0]   held_num;
    logic [63:0]   held_txt;
    logic [7:0]    held_len;
    cst_pkg::res_t burst[cst_pkg::MAX_RESULTS];
    int            burst_n;

    function automatic bit is_digit(logic [7:0] c);
        return c >= cst_pkg::CH_0 && c <= cst_pkg::CH_9;
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= cst_pkg::CH_LA && c <= cst_pkg::CH_LZ) ||
               (c >= cst_pkg::CH_UA && c <= cst_pkg::CH_UZ);
    endfunction

    function automatic logic [30:0] sat31(logic [31:0] v);
        return (v > 32'h7FFF_FFFF) ? 31'h7FFF_FFFF : v[30:0];
    endfunction

    function automatic void put_tok(logic [3:0] k, logic [30:0] iv, logic [31:0] fv,
                                    logic [7:0] fd, logic [63:0] txt, logic [7:0] len);
        cst_pkg::res_t r;
        r.kind        = k;
        r.int_value   = iv;
        r.frac_value  = fv;
        r.frac_digits = fd;
        r.text        = txt;
        r.text_length = len;
        r.last        = 1'b0;
        if (burst_n < cst_pkg::MAX_RESULTS)
        begin
            burst[burst_n] = r;
            burst_n++;
        end
    endfunction

    function automatic void reset_token();
        num_acc = '0;
        txt_acc = '0;
        len_acc = '0;
    endfunction

    function automatic void drop_held();
        held_n   = '0;
        held_num = '0;
        held_txt = '0;
        held_len = '0;
    endfunction

    function automatic void append_char(logic [7:0] c);
        if (len_acc < cst_pkg::TEXT_CHARS)
            txt_acc[8*len_acc +: 8] = c;
        if (len_acc != 8'hFF)
            len_acc++;
    endfunction

    // Flush a held int, and a held dot behind it, as plain tokens.
    function automatic void release_held();
        if (held_n >= 2'd1)
            put_tok(cst_pkg::KIND_INT, sat31(held_num), '0, '0, held_txt, held_len);
        if (held_n >= 2'd2)
            put_tok(cst_pkg::KIND_DOT, '0, '0, '0, 64'(cst_pkg::CH_DOT), 8'd1);
        drop_held();
    endfunction

    function automatic void put_plain(logic [3:0] k, logic [63:0] txt, logic [7:0] len);
        release_held();
        put_tok(k, '0, '0, '0, txt, len);
    endfunction

    // Merge the held int and dot with the fraction in progress.
    function automatic void put_float();
        logic [63:0] t;
        int          total;
        t = held_txt;
        if (held_len < cst_pkg::TEXT_CHARS)
            t[8*held_len +: 8] = cst_pkg::CH_DOT;
        for (int i = 0; i < cst_pkg::TEXT_CHARS; i++)
            if (i < len_acc && held_len + 1 + i < cst_pkg::TEXT_CHARS)
                t[8*(held_len + 1 + i) +: 8] = txt_acc[8*i +: 8];
        total = held_len + 1 + len_acc;
        if (total > 255)
            total = 255;
        put_tok(cst_pkg::KIND_FLOAT, sat31(held_num), num_acc, len_acc, t, 8'(total));
    endfunction

    // An int just ended: it completes a float, or it is held back in case
    // a dot and a fraction follow.
    function automatic void close_number();
        if (held_n >= 2'd2)
        begin
            put_float();
            drop_held();
        end
        else
        begin
            if (held_n == 2'd1)
                put_tok(cst_pkg::KIND_INT, sat31(held_num), '0, '0, held_txt, held_len);
            held_n   = 2'd1;
            held_num = num_acc;
            held_txt = txt_acc;
            held_len = len_acc;
        end
        reset_token();
    endfunction

    function automatic void take_dot();
        if (held_n == 2'd1)
            held_n = 2'd2;
        else
        begin
            release_held();
            put_tok(cst_pkg::KIND_DOT, '0, '0, '0, 64'(cst_pkg::CH_DOT), 8'd1);
        end
    endfunction

    function automatic void scan_plain(logic [7:0] c);
        scan_mode = SCAN_IDLE;
        case (c)
            cst_pkg::CH_SP, cst_pkg::CH_TAB, cst_pkg::CH_CR, cst_pkg::CH_LF: ;
            cst_pkg::CH_DOT:   take_dot();
            cst_pkg::CH_COLON: put_plain(cst_pkg::KIND_COLON, 64'(c), 8'd1);
            cst_pkg::CH_SEMI:  put_plain(cst_pkg::KIND_SEMI, 64'(c), 8'd1);
            cst_pkg::CH_COMMA: put_plain(cst_pkg::KIND_COMMA, 64'(c), 8'd1);
            cst_pkg::CH_PLUS:  put_plain(cst_pkg::KIND_PLUS, 64'(c), 8'd1);
            cst_pkg::CH_MINUS: put_plain(cst_pkg::KIND_MINUS, 64'(c), 8'd1);
            cst_pkg::CH_STAR:  put_plain(cst_pkg::KIND_MUL, 64'(c), 8'd1);
            cst_pkg::CH_EQ:    put_plain(cst_pkg::KIND_ASSIGN, 64'(c), 8'd1);
            cst_pkg::CH_LPAR:  put_plain(cst_pkg::KIND_LPAR, 64'(c), 8'd1);
            cst_pkg::CH_RPAR:  put_plain(cst_pkg::KIND_RPAR, 64'(c), 8'd1);
            cst_pkg::CH_SLASH: scan_mode = SCAN_SLASH;
            default:
            begin
                if (is_digit(c))
                begin
                    reset_token();
                    num_acc = 32'(c - cst_pkg::CH_0);
                    append_char(c);
                    scan_mode = SCAN_NUM;
                end
                else if (is_letter(c))
                begin
                    reset_token();
                    append_char(c);
                    scan_mode = SCAN_WORD;
                end
                else
                    put_plain(cst_pkg::KIND_UNKNOWN, 64'(c), 8'd1);
            end
        endcase
    endfunction

    function automatic void clear_lexer();
        scan_mode = SCAN_IDLE;
        reset_token();
        drop_held();
    endfunction

    // Step the predictor by one source transfer. The tokens land in burst[].
    function automatic void lex_step(logic [7:0] c, logic fin);
        logic [35:0] grown;
        burst_n = 0;
        if (fin)
        begin
            case (scan_mode)
                SCAN_NUM:   close_number();
                SCAN_WORD:  put_plain(cst_pkg::KIND_IDENT, txt_acc, len_acc);
                SCAN_SLASH: put_plain(cst_pkg::KIND_DIV, 64'(cst_pkg::CH_SLASH), 8'd1);
                default: ;
            endcase
            release_held();
            put_tok(cst_pkg::KIND_END, '0, '0, '0, '0, '0);
            clear_lexer();
        end
        else
        begin
            case (scan_mode)
                SCAN_NUM:
                    if (is_digit(c))
                    begin
                        grown = 36'(num_acc) * 36'd10 + 36'(c - cst_pkg::CH_0);
                        num_acc = (grown[35:32] != 4'd0) ? 32'hFFFF_FFFF : grown[31:0];
                        append_char(c);
                    end
                    else
                    begin
                        close_number();
                        scan_plain(c);
                    end
                SCAN_WORD:
                    if (is_digit(c) || is_letter(c))
                        append_char(c);
                    else
                    begin
                        put_plain(cst_pkg::KIND_IDENT, txt_acc, len_acc);
                        reset_token();
                        scan_plain(c);
                    end
                SCAN_SLASH:
                    if (c == cst_pkg::CH_SLASH)
                        scan_mode = SCAN_LINE_CMT;
                    else if (c == cst_pkg::CH_STAR)
                        scan_mode = SCAN_BLOCK_CMT;
                    else
                    begin
                        put_plain(cst_pkg::KIND_DIV, 64'(cst_pkg::CH_SLASH), 8'd1);
                        scan_plain(c);
                    end
                SCAN_LINE_CMT:
                    if (c == cst_pkg::CH_LF)
                        scan_mode = SCAN_IDLE;
                SCAN_BLOCK_CMT:
                    if (c == cst_pkg::CH_STAR)
                        scan_mode = SCAN_BLOCK_STAR;
                SCAN_BLOCK_STAR:
                    if (c == cst_pkg::CH_SLASH)
                        scan_mode = SCAN_IDLE;
                    else if (c != cst_pkg::CH_STAR)
                        scan_mode = SCAN_BLOCK_CMT;
                default:
                    scan_plain(c);
            endcase
        end
        if (burst_n > 0)
            burst[burst_n-1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus plan
    // ------------------------------------------------------------------
    function automatic void add_row(logic [7:0] c, logic fin);
        stim_row_t r;
        r.chr   = c;
        r.fin   = fin;
        r.typed = 1'b0;
        r.want  = '0;
        plan.push_back(r);
    endfunction

    // Row whose one token can be written down directly: a single-character
    // token, or the end token (which carries no text) when fin is set.
    function automatic void add_typed(logic [7:0] c, logic fin, logic [3:0] k);
        stim_row_t r;
        r.chr              = c;
        r.fin              = fin;
        r.typed            = 1'b1;
        r.want             = '0;
        r.want.kind        = k;
        r.want.text        = fin ? 64'd0 : 64'(c);
        r.want.text_length = fin ? 8'd0 : 8'd1;
        r.want.last        = 1'b1;
        plan.push_back(r);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_row(s[i], 1'b0);
    endfunction

    function automatic void add_digits(int n);
        for (int i = 0; i < n; i++)
            add_row(8'(cst_pkg::CH_0 + $urandom_range(0, 9)), 1'b0);
    endfunction

    function automatic logic [7:0] rand_letter();
        return $urandom_range(0, 1) ? 8'(cst_pkg::CH_LA + $urandom_range(0, 25))
                                    : 8'(cst_pkg::CH_UA + $urandom_range(0, 25));
    endfunction

    // Mostly short numbers, with a tail long enough to saturate.
    function automatic void add_number();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            add_digits($urandom_range(1, 3));
        else if (pick < 9)
            add_digits($urandom_range(4, 9));
        else
            add_digits($urandom_range(10, 13));
    endfunction

    // Whitespace or a comment that the lexer drops.
    function automatic void add_gap(int pick);
        int n;
        logic [7:0] c;
        string blanks;
        blanks = " \t\r\n";
        n = $urandom_range(0, 6);
        case (pick)
            0:
            begin
                for (int i = 0; i < $urandom_range(1, 3); i++)
                    add_row(blanks[$urandom_range(0, 3)], 1'b0);
            end
            1:
            begin
                add_text("//");
                for (int i = 0; i < n; i++)
                begin
                    c = 8'($urandom_range(0, 255));
                    add_row(c == cst_pkg::CH_LF ? cst_pkg::CH_SP : c, 1'b0);
                end
                add_row(cst_pkg::CH_LF, 1'b0);
            end
            default:
            begin
                add_text("/*");
                for (int i = 0; i < n; i++)
                    add_row($urandom_range(0, 2) == 0 ? cst_pkg::CH_STAR
                                                      : 8'($urandom_range(0, 255)),
                            1'b0);
                add_text("*/");
            end
        endcase
    endfunction

    // One random fragment: mostly well-formed tokens, some noise and some
    // broken sequences.
    function automatic void add_fragment();
        int    pick;
        string punct;
        punct = "():;,+-*=./";
        pick = $urandom_range(0, 99);
        if (pick < 18)
            add_number();
        else if (pick < 33)
        begin
            add_number();
            if ($urandom_range(0, 3) == 0)
                add_gap($urandom_range(0, 2));
            add_row(cst_pkg::CH_DOT, 1'b0);
            if ($urandom_range(0, 3) == 0)
                add_gap($urandom_range(0, 2));
            if ($urandom_range(0, 7) != 0)
                add_number();
        end
        else if (pick < 48)
        begin
            add_row(rand_letter(), 1'b0);
            for (int i = 0; i < $urandom_range(0, 11); i++)
                add_row($urandom_range(0, 2) == 0 ? 8'(cst_pkg::CH_0 + $urandom_range(0, 9))
                                                  : rand_letter(), 1'b0);
        end
        else if (pick < 64)
            add_row(punct[$urandom_range(0, punct.len() - 1)], 1'b0);
        else if (pick < 82)
            add_gap($urandom_range(0, 2));
        else if (pick < 90)
            add_row(8'($urandom_range(0, 255)), 1'b0);
        else if (pick < 94)
        begin
            // Saturation boundaries of the int part and of the fraction
            case ($urandom_range(0, 3))
                0: add_text("2147483647");
                1: add_text("2147483648");
                2: add_text("0.4294967295");
                default: add_text("0.4294967296");
            endcase
        end
        else if (pick < 97)
        begin
            // Slash followed by anything at all
            add_row(cst_pkg::CH_SLASH, 1'b0);
            add_row(8'($urandom_range(0, 255)), 1'b0);
        end
        else
            add_row(8'($urandom), 1'b1);
    endfunction

    function automatic void build_plan();
        // Directed part: the end token straight after reset, the extreme
        // bytes, every single-character token, int then letter, slash
        // followed by a blank, an empty block comment and a float at end.
        add_typed(8'h00, 1'b1, cst_pkg::KIND_END);
        add_typed(8'h00, 1'b0, cst_pkg::KIND_UNKNOWN);
        add_typed(8'hFF, 1'b0, cst_pkg::KIND_UNKNOWN);
        add_typed(cst_pkg::CH_LPAR, 1'b0, cst_pkg::KIND_LPAR);
        add_typed(cst_pkg::CH_RPAR, 1'b0, cst_pkg::KIND_RPAR);
        add_typed(cst_pkg::CH_COLON, 1'b0, cst_pkg::KIND_COLON);
        add_typed(cst_pkg::CH_SEMI, 1'b0, cst_pkg::KIND_SEMI);
        add_typed(cst_pkg::CH_COMMA, 1'b0, cst_pkg::KIND_COMMA);
        add_typed(cst_pkg::CH_PLUS, 1'b0, cst_pkg::KIND_PLUS);
        add_typed(cst_pkg::CH_MINUS, 1'b0, cst_pkg::KIND_MINUS);
        add_typed(cst_pkg::CH_STAR, 1'b0, cst_pkg::KIND_MUL);
        add_typed(cst_pkg::CH_EQ, 1'b0, cst_pkg::KIND_ASSIGN);
        add_text("12a./ /**/3.5");
        add_row(8'hA5, 1'b1);

        // Random part: one float long enough to saturate every count, then
        // random fragments, closed by an end mark.
        rand_start = plan.size();
        add_text("1.");
        add_digits(257);
        while (plan.size() < ITEMS)
            add_fragment();
        add_row(8'h5A, 1'b1);
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report(string msg);
        errors++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // Sample both channels at the rising edge. A token can only come from a
    // transfer registered in the item register first, so its expectation is already queued.
    // Hold the predictor at its reset state while rst_n is low.
    always @(posedge clk)
    begin
        cst_pkg::res_t want;
        if (!rst_n)
            clear_lexer();
        else
        begin
            if (tok_valid && !tok_stall)
            begin
                if (tok_expect.size() == 0)
                    report($sformatf("token kind %0d with no token pending", kind));
                else
                begin
                    want = tok_expect.pop_front();
                    check_field("kind", kind, want.kind);
                    check_field("int_value", int_value, want.int_value);
                    check_field("frac_value", frac_value, want.frac_value);
                    check_field("frac_digits", frac_digits, want.frac_digits);
                    check_field("text", text, want.text);
                    check_field("text_length", text_length, want.text_length);
                    check_field("last", last, want.last);
                end
            end
            if (src_valid && !src_stall)
            begin
                lex_step(plan[row_idx].chr, plan[row_idx].fin);
                if (plan[row_idx].typed)
                    tok_expect.push_back(plan[row_idx].want);
                else
                    for (int k = 0; k < burst_n; k++)
                        tok_expect.push_back(burst[k]);
            end
        end
    end

    // Give up at the cycle ceiling.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Token sink: raise stall at random before each token, with
    // stretches of no stall at all.
    // ------------------------------------------------------------------
    initial
    begin
        int hold;
        bit sink_burst;
        sink_burst = 1'b0;
        tok_stall  = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                sink_burst = !sink_burst;
            hold = sink_burst ? 0 : $urandom_range(0, 7);
            repeat (hold)
            begin
                @(negedge clk);
                tok_stall <= 1'b1;
            end
            @(negedge clk);
            tok_stall <= 1'b0;
            do @(posedge clk); while (!tok_valid);
        end
    end

    // ------------------------------------------------------------------
    // Source driver and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int  gap;
        bit  src_burst;
        int  half;
        rst_n     = 1'b0;
        src_valid = 1'b0;
        ch        = '0;
        at_end    = 1'b0;
        row_idx   = 0;
        src_burst = 1'b0;
        build_plan();
        half = plan.size() / 2;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < plan.size(); i++)
        begin
            // Hold off at the start of the random part and halfway through
            // until every pending token has drained.
            if (i == rand_start || i == half)
            begin
                @(negedge clk);
                src_valid <= 1'b0;
                while (tok_expect.size() != 0)
                    @(posedge clk);
            end
            if ($urandom_range(0, 31) == 0)
                src_burst = !src_burst;
            gap = src_burst ? 0 : $urandom_range(0, 7);
            // Idle cycles carry junk on the payload.
            repeat (gap)
            begin
                @(negedge clk);
                src_valid <= 1'b0;
                ch        <= 8'($urandom);
                at_end    <= 1'($urandom);
            end
            @(negedge clk);
            row_idx    = i;
            src_valid <= 1'b1;
            ch        <= plan[i].chr;
            at_end    <= plan[i].fin;
            // Advance once the transfer has taken place.
            do @(posedge clk); while (src_stall);
        end
        @(negedge clk);
        src_valid <= 1'b0;

        while (tok_expect.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
